FILE: src/scvq_pkg.sv
// ----------------------------------------------------------------------------
// scvq_pkg
// Shared types, constants and helpers for the second-chance victim queue.
// ----------------------------------------------------------------------------
package scvq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int NUM_SLOTS   = 64;
  localparam int SLOT_W      = 6;
  localparam int HOLD_W      = 8;
  localparam int OCC_W       = 7;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int GUARD_LIM   = 2 * QUEUE_DEPTH + 4;
  localparam int GUARD_W     = $clog2(GUARD_LIM + 1);

  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_HIT     = 2'd1,
    OP_RELEASE = 2'd2,
    OP_VICTIM  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_HSCAN,
    ST_HTAIL,
    ST_RDEC,
    ST_VREAD,
    ST_VHOLD,
    ST_VDEC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic set_err;
    logic do_insert;
    logic hold_rd;
    logic scan_start;
    logic scan_step;
    logic hit_tail;
    logic rel_dec;
    logic v_start;
    logic v_read;
    logic v_check;
    logic v_decide;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic illegal;
    logic q_empty;
    logic scan_done;
    logic v_stop;
    logic v_removed;
    logic out_free;
  } sts_t;

  // circular position: base plus offset, offset at most QUEUE_DEPTH
  function automatic logic [PTR_W-1:0] pos_wrap(logic [PTR_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

FILE: src/scvq_if.sv
// ----------------------------------------------------------------------------
// scvq_if
// Request and result channels of the victim queue, valid/ready handshake.
// ----------------------------------------------------------------------------
interface scvq_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [scvq_pkg::SLOT_W-1:0] slot;

  modport source (output valid, output operation, output slot, input ready);
  modport sink   (input valid, input operation, input slot, output ready);
endinterface

interface scvq_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [scvq_pkg::SLOT_W-1:0] victim_slot;
  logic                        error;
  logic [scvq_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, output found, output victim_slot, output error,
                  output occupancy, input ready);
  modport sink   (input valid, input found, input victim_slot, input error,
                  input occupancy, output ready);
endinterface

FILE: src/scvq_ctrl.sv
// ----------------------------------------------------------------------------
// scvq_ctrl
// Sequencer: walks each request through decode, scan and rotation steps.
// ----------------------------------------------------------------------------
module scvq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  scvq_pkg::sts_t sts,
  output scvq_pkg::cmd_t cmd
);

  scvq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scvq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      scvq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = scvq_pkg::ST_DECODE;
        end
      end
      scvq_pkg::ST_DECODE: begin
        unique case (sts.op)
          scvq_pkg::OP_INSERT: begin
            if (sts.illegal) begin
              cmd.set_err = 1'b1;
            end else begin
              cmd.do_insert = 1'b1;
            end
            state_nxt = scvq_pkg::ST_FIN;
          end
          scvq_pkg::OP_HIT: begin
            if (sts.illegal) begin
              cmd.set_err = 1'b1;
              state_nxt   = scvq_pkg::ST_FIN;
            end else begin
              cmd.hold_rd    = 1'b1;
              cmd.scan_start = 1'b1;
              state_nxt      = scvq_pkg::ST_HSCAN;
            end
          end
          scvq_pkg::OP_RELEASE: begin
            if (sts.illegal) begin
              cmd.set_err = 1'b1;
              state_nxt   = scvq_pkg::ST_FIN;
            end else begin
              cmd.hold_rd = 1'b1;
              state_nxt   = scvq_pkg::ST_RDEC;
            end
          end
          scvq_pkg::OP_VICTIM: begin
            if (sts.q_empty) begin
              state_nxt = scvq_pkg::ST_FIN;
            end else begin
              cmd.v_start = 1'b1;
              state_nxt   = scvq_pkg::ST_VREAD;
            end
          end
          default: state_nxt = scvq_pkg::ST_FIN;
        endcase
      end
      scvq_pkg::ST_HSCAN: begin
        if (sts.scan_done) begin
          state_nxt = scvq_pkg::ST_HTAIL;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      scvq_pkg::ST_HTAIL: begin
        cmd.hit_tail = 1'b1;
        state_nxt    = scvq_pkg::ST_FIN;
      end
      scvq_pkg::ST_RDEC: begin
        cmd.rel_dec = 1'b1;
        state_nxt   = scvq_pkg::ST_FIN;
      end
      scvq_pkg::ST_VREAD: begin
        cmd.v_read = 1'b1;
        state_nxt  = scvq_pkg::ST_VHOLD;
      end
      scvq_pkg::ST_VHOLD: begin
        if (sts.v_stop) begin
          state_nxt = scvq_pkg::ST_FIN;
        end else begin
          cmd.v_check = 1'b1;
          state_nxt   = scvq_pkg::ST_VDEC;
        end
      end
      scvq_pkg::ST_VDEC: begin
        cmd.v_decide = 1'b1;
        state_nxt    = sts.v_removed ? scvq_pkg::ST_FIN : scvq_pkg::ST_VREAD;
      end
      scvq_pkg::ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = scvq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = scvq_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: src/scvq_dp.sv
// ----------------------------------------------------------------------------
// scvq_dp
// Datapath: circular order memory, holder count memory, mark flops and the
// result register.
// ----------------------------------------------------------------------------
module scvq_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    in_operation,
  input  logic [scvq_pkg::SLOT_W-1:0]   in_slot,
  input  scvq_pkg::cmd_t                cmd,
  output scvq_pkg::sts_t                sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [scvq_pkg::SLOT_W-1:0]   out_victim_slot,
  output logic                          out_error,
  output logic [scvq_pkg::OCC_W-1:0]    out_occupancy
);

  // memories
  logic [scvq_pkg::SLOT_W-1:0] ord_mem  [scvq_pkg::QUEUE_DEPTH];
  logic [scvq_pkg::HOLD_W-1:0] hold_mem [scvq_pkg::NUM_SLOTS];
  logic [scvq_pkg::SLOT_W-1:0] ord_q_r;
  logic [scvq_pkg::HOLD_W-1:0] hold_q_r;

  // queue control
  logic [scvq_pkg::PTR_W-1:0]     head_r, head_nxt;
  logic [scvq_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [scvq_pkg::NUM_SLOTS-1:0] queued_r, queued_nxt;
  logic [scvq_pkg::NUM_SLOTS-1:0] used_r, used_nxt;

  // request
  scvq_pkg::op_t               op_r, op_nxt;
  logic [scvq_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic                        found_r, found_nxt;
  logic [scvq_pkg::SLOT_W-1:0] victim_r, victim_nxt;
  logic                        err_r, err_nxt;

  // hit scan
  logic [scvq_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic [scvq_pkg::CNT_W-1:0] proc_r, proc_nxt;
  logic                       pend_r, pend_nxt;
  logic                       hfound_r, hfound_nxt;

  // victim rotation
  logic                        vfirst_r, vfirst_nxt;
  logic                        laps_r, laps_nxt;
  logic [scvq_pkg::GUARD_W-1:0] guard_r, guard_nxt;
  logic [scvq_pkg::SLOT_W-1:0] first_r, first_nxt;
  logic [scvq_pkg::SLOT_W-1:0] cur_r, cur_nxt;

  // result register
  logic                        ovalid_r, ovalid_nxt;
  logic                        ofound_r, ofound_nxt;
  logic [scvq_pkg::SLOT_W-1:0] ovictim_r, ovictim_nxt;
  logic                        oerr_r, oerr_nxt;
  logic [scvq_pkg::OCC_W-1:0]  oocc_r, oocc_nxt;

  // memory ports
  logic                        ord_re, ord_we;
  logic [scvq_pkg::PTR_W-1:0]  ord_raddr, ord_waddr;
  logic [scvq_pkg::CNT_W-1:0]  ord_woff;
  logic [scvq_pkg::SLOT_W-1:0] ord_wdata;
  logic                        hold_re, hold_we;
  logic [scvq_pkg::SLOT_W-1:0] hold_raddr, hold_waddr;
  logic [scvq_pkg::HOLD_W-1:0] hold_wdata;

  logic scan_more;
  logic v_used;
  logic v_remove;

  assign scan_more = idx_r < count_r;
  assign v_used    = used_r[cur_r];
  assign v_remove  = !v_used && (hold_q_r == scvq_pkg::HOLD_W'(1));

  // status
  always_comb begin
    sts.op = op_r;
    unique case (op_r)
      scvq_pkg::OP_INSERT:  sts.illegal = queued_r[slot_r] ||
                                          (count_r == scvq_pkg::CNT_W'(scvq_pkg::QUEUE_DEPTH));
      scvq_pkg::OP_HIT:     sts.illegal = !queued_r[slot_r];
      scvq_pkg::OP_RELEASE: sts.illegal = !queued_r[slot_r];
      scvq_pkg::OP_VICTIM:  sts.illegal = 1'b0;
      default:              sts.illegal = 1'b0;
    endcase
    sts.q_empty   = (count_r == '0);
    sts.scan_done = (idx_r == count_r) && !pend_r;
    // lap limit: first head entry back at the head a second time, or guard count at GUARD_LIM
    sts.v_stop    = !vfirst_r &&
                    (((ord_q_r == first_r) && laps_r) ||
                     (guard_r >= scvq_pkg::GUARD_W'(scvq_pkg::GUARD_LIM)));
    sts.v_removed = v_remove;
    sts.out_free  = !ovalid_r || out_ready;
  end

  // order memory ports
  always_comb begin
    ord_re    = (cmd.scan_step && scan_more) || cmd.v_read;
    ord_raddr = scvq_pkg::pos_wrap(head_r, cmd.v_read ? '0 : idx_r);
    ord_we    = 1'b0;
    ord_woff  = count_r;
    ord_wdata = slot_r;
    if (cmd.do_insert) begin
      ord_we = 1'b1;
    end
    // entries behind the hit slot move one place toward the head
    if (cmd.scan_step && pend_r && hfound_r) begin
      ord_we    = 1'b1;
      ord_woff  = proc_r - scvq_pkg::CNT_W'(1);
      ord_wdata = ord_q_r;
    end
    if (cmd.hit_tail) begin
      ord_we   = 1'b1;
      ord_woff = count_r - scvq_pkg::CNT_W'(1);
    end
    if (cmd.v_decide && !v_remove) begin
      ord_we    = 1'b1;
      ord_wdata = cur_r;
    end
    ord_waddr = scvq_pkg::pos_wrap(head_r, ord_woff);
  end

  // holder memory ports
  always_comb begin
    hold_re    = cmd.hold_rd || cmd.v_check;
    hold_raddr = cmd.v_check ? ord_q_r : slot_r;
    hold_we    = 1'b0;
    hold_waddr = slot_r;
    hold_wdata = scvq_pkg::HOLD_W'(1);
    if (cmd.do_insert) begin
      hold_we = 1'b1;
    end
    if (cmd.hit_tail) begin
      hold_we    = 1'b1;
      hold_wdata = (hold_q_r == scvq_pkg::HOLD_MAX) ? hold_q_r
                                                    : hold_q_r + scvq_pkg::HOLD_W'(1);
    end
    if (cmd.rel_dec && (hold_q_r != '0)) begin
      hold_we    = 1'b1;
      hold_wdata = hold_q_r - scvq_pkg::HOLD_W'(1);
    end
    if (cmd.v_decide && v_remove) begin
      hold_we    = 1'b1;
      hold_waddr = cur_r;
      hold_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord_q_r <= ord_mem[ord_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (hold_we) begin
      hold_mem[hold_waddr] <= hold_wdata;
    end
    if (hold_re) begin
      hold_q_r <= hold_mem[hold_raddr];
    end
  end

  // next state
  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    queued_nxt  = queued_r;
    used_nxt    = used_r;
    op_nxt      = op_r;
    slot_nxt    = slot_r;
    found_nxt   = found_r;
    victim_nxt  = victim_r;
    err_nxt     = err_r;
    idx_nxt     = idx_r;
    proc_nxt    = proc_r;
    pend_nxt    = pend_r;
    hfound_nxt  = hfound_r;
    vfirst_nxt  = vfirst_r;
    laps_nxt    = laps_r;
    guard_nxt   = guard_r;
    first_nxt   = first_r;
    cur_nxt     = cur_r;
    ovalid_nxt  = ovalid_r;
    ofound_nxt  = ofound_r;
    ovictim_nxt = ovictim_r;
    oerr_nxt    = oerr_r;
    oocc_nxt    = oocc_r;

    if (cmd.latch_in) begin
      op_nxt     = scvq_pkg::op_t'(in_operation);
      slot_nxt   = in_slot;
      found_nxt  = 1'b0;
      victim_nxt = '0;
      err_nxt    = 1'b0;
    end
    if (cmd.set_err) begin
      err_nxt = 1'b1;
    end
    if (cmd.do_insert) begin
      count_nxt          = count_r + scvq_pkg::CNT_W'(1);
      queued_nxt[slot_r] = 1'b1;
      used_nxt[slot_r]   = 1'b0;
    end
    if (cmd.scan_start) begin
      idx_nxt    = '0;
      pend_nxt   = 1'b0;
      hfound_nxt = 1'b0;
    end
    if (cmd.scan_step) begin
      if (scan_more) begin
        idx_nxt  = idx_r + scvq_pkg::CNT_W'(1);
        proc_nxt = idx_r;
        pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
      if (pend_r && !hfound_r && (ord_q_r == slot_r)) begin
        hfound_nxt = 1'b1;
      end
    end
    if (cmd.hit_tail) begin
      used_nxt[slot_r] = 1'b1;
    end
    if (cmd.v_start) begin
      vfirst_nxt = 1'b1;
      laps_nxt   = 1'b0;
      guard_nxt  = '0;
    end
    if (cmd.v_check) begin
      cur_nxt    = ord_q_r;
      vfirst_nxt = 1'b0;
      if (vfirst_r) begin
        first_nxt = ord_q_r;
      end else begin
        laps_nxt  = laps_r || (ord_q_r == first_r);
        guard_nxt = guard_r + scvq_pkg::GUARD_W'(1);
      end
    end
    if (cmd.v_decide) begin
      // head entry leaves the head; unless removed it is written at the tail
      head_nxt = scvq_pkg::pos_wrap(head_r, scvq_pkg::CNT_W'(1));
      if (v_used) begin
        used_nxt[cur_r] = 1'b0;
      end
      if (v_remove) begin
        queued_nxt[cur_r] = 1'b0;
        count_nxt         = count_r - scvq_pkg::CNT_W'(1);
        found_nxt         = 1'b1;
        victim_nxt        = cur_r;
      end
    end
    if (cmd.load_out) begin
      ovalid_nxt  = 1'b1;
      ofound_nxt  = found_r;
      ovictim_nxt = victim_r;
      oerr_nxt    = err_r;
      oocc_nxt    = scvq_pkg::OCC_W'(count_r);
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      queued_r <= '0;
      used_r   <= '0;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      queued_r <= queued_nxt;
      used_r   <= used_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    slot_r    <= slot_nxt;
    found_r   <= found_nxt;
    victim_r  <= victim_nxt;
    err_r     <= err_nxt;
    idx_r     <= idx_nxt;
    proc_r    <= proc_nxt;
    hfound_r  <= hfound_nxt;
    vfirst_r  <= vfirst_nxt;
    laps_r    <= laps_nxt;
    guard_r   <= guard_nxt;
    first_r   <= first_nxt;
    cur_r     <= cur_nxt;
    ofound_r  <= ofound_nxt;
    ovictim_r <= ovictim_nxt;
    oerr_r    <= oerr_nxt;
    oocc_r    <= oocc_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_found       = ofound_r;
  assign out_victim_slot = ovictim_r;
  assign out_error       = oerr_r;
  assign out_occupancy   = oocc_r;

endmodule

FILE: src/second_chance_victim_queue_unit.sv
// ----------------------------------------------------------------------------
// second_chance_victim_queue_unit
// Second-chance recency queue of cache slots with victim selection.
// ----------------------------------------------------------------------------
// one request at a time; a new request is taken once the previous result is
// in the output register. insert, release and illegal requests need no scan.
// hit walks the order memory one entry a cycle to close the gap. victim
// takes each head entry through order read, holder read and decision, at
// most 2 * occupancy entries, and the search may give up without a victim.
// synchronous reset empties the queue.
module second_chance_victim_queue_unit (
  input logic        clk,
  input logic        rst_n,
  scvq_in_if.sink    in_ch,
  scvq_out_if.source out_ch
);

  scvq_pkg::cmd_t cmd;
  scvq_pkg::sts_t sts;
  logic           in_ready;

  assign in_ch.ready = in_ready;

  scvq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scvq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_ch.operation),
    .in_slot         (in_ch.slot),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_found       (out_ch.found),
    .out_victim_slot (out_ch.victim_slot),
    .out_error       (out_ch.error),
    .out_occupancy   (out_ch.occupancy)
  );

endmodule

FILE: src/scvq_checker.sv
// ----------------------------------------------------------------------------
// scvq_checker
// Port-level checks of the victim queue, bound to the top level.
// ----------------------------------------------------------------------------
module scvq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_found,
  input logic [scvq_pkg::SLOT_W-1:0] out_victim_slot,
  input logic                        out_error
);

  // pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_victim_slot))
    else $error("result dropped or changed while stalled");

  // one request in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in progress");

  a_found_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> !out_error)
    else $error("victim returned together with error");

  a_no_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_victim_slot == '0)
    else $error("victim slot nonzero without a victim");

endmodule

bind second_chance_victim_queue_unit scvq_checker u_scvq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_found       (out_ch.found),
  .out_victim_slot (out_ch.victim_slot),
  .out_error       (out_ch.error)
);
